// ===== rtl/core/stm_pkg.sv =====
// Shared constants, codes and control structs of the stereo timestamp matcher.
// Used by stm_queue, stm_alu, stm_ctrl and stereo_timestamp_matcher.
package stm_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int TAG_BITS    = 8;

  localparam int STAMP_W = 64;
  localparam int TAG_W   = 8;
  localparam int WIN_W   = 32;
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W  = $clog2(2 * QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd3000000;

  typedef enum logic [1:0] {
    KIND_PAIR    = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_READ,
    ST_SUB,
    ST_ABS,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic pop_left;
    logic pop_right;
  } q_cmd_t;

  typedef struct packed {
    logic ne_left;
    logic ne_right;
    logic full_left;
    logic full_right;
  } q_stat_t;

  typedef struct packed {
    logic sub_en;
    logic abs_en;
  } alu_cmd_t;

  typedef struct packed {
    logic in_win;
    logic neg;
    logic nonzero;
  } alu_stat_t;

  typedef struct packed {
    logic  load;
    kind_e kind;
    logic  cam;
    logic  last;
  } emit_t;

endpackage

// ===== rtl/core/stm_queue.sv =====
// Two frame FIFOs, one per camera, sharing one stamp memory and one tag memory.
// Depends on stm_pkg for depths, widths and the command and status structs.
module stm_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  stm_pkg::q_cmd_t                  cmd_i,
  input  logic                             wr_cam_i,
  input  logic [stm_pkg::TAG_BITS-1:0]     wr_tag_i,
  input  logic [stm_pkg::STAMP_W-1:0]      wr_stamp_i,
  output stm_pkg::q_stat_t                 stat_o,
  output logic [stm_pkg::STAMP_W-1:0]      stamp_left_o,
  output logic [stm_pkg::STAMP_W-1:0]      stamp_right_o,
  output logic [stm_pkg::TAG_BITS-1:0]     tag_left_o,
  output logic [stm_pkg::TAG_BITS-1:0]     tag_right_o
);

  localparam int SUM_W = stm_pkg::IDX_W + 1;

  logic [stm_pkg::STAMP_W-1:0]  stamp_mem [2*stm_pkg::QUEUE_DEPTH];
  logic [stm_pkg::TAG_BITS-1:0] tag_mem   [2*stm_pkg::QUEUE_DEPTH];

  logic [stm_pkg::IDX_W-1:0] head_q [2];
  logic [stm_pkg::IDX_W-1:0] head_d [2];
  logic [stm_pkg::CNT_W-1:0] fill_q [2];
  logic [stm_pkg::CNT_W-1:0] fill_d [2];

  logic [stm_pkg::STAMP_W-1:0]  stamp_left_q, stamp_right_q;
  logic [stm_pkg::TAG_BITS-1:0] tag_left_q, tag_right_q;

  logic [SUM_W-1:0]          wr_sum;
  logic [stm_pkg::IDX_W-1:0] wr_idx;
  logic [stm_pkg::ADDR_W-1:0] wr_addr, rd_addr_left, rd_addr_right;
  logic                      pop [2];

  function automatic logic [stm_pkg::ADDR_W-1:0] slot_addr(
      input logic cam, input logic [stm_pkg::IDX_W-1:0] idx);
    logic [stm_pkg::ADDR_W-1:0] base;
    base = cam ? stm_pkg::ADDR_W'(stm_pkg::QUEUE_DEPTH) : '0;
    return base + stm_pkg::ADDR_W'(idx);
  endfunction

  always_comb begin
    // The tail slot is the head plus the fill level, wrapped at the depth.
    wr_sum = SUM_W'(head_q[wr_cam_i]) + SUM_W'(fill_q[wr_cam_i]);
    if (wr_sum >= SUM_W'(stm_pkg::QUEUE_DEPTH)) begin
      wr_sum = wr_sum - SUM_W'(stm_pkg::QUEUE_DEPTH);
    end
    wr_idx        = wr_sum[stm_pkg::IDX_W-1:0];
    wr_addr       = slot_addr(wr_cam_i, wr_idx);
    rd_addr_left  = slot_addr(1'b0, head_q[0]);
    rd_addr_right = slot_addr(1'b1, head_q[1]);
  end

  assign pop[0] = cmd_i.pop_left;
  assign pop[1] = cmd_i.pop_right;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      head_d[c] = head_q[c];
      fill_d[c] = fill_q[c];
      if (cmd_i.wr_en && (wr_cam_i == c[0])) begin
        fill_d[c] = fill_q[c] + stm_pkg::CNT_W'(1);
      end
      if (pop[c]) begin
        fill_d[c] = fill_q[c] - stm_pkg::CNT_W'(1);
        if (head_q[c] == stm_pkg::IDX_W'(stm_pkg::QUEUE_DEPTH - 1)) begin
          head_d[c] = '0;
        end else begin
          head_d[c] = head_q[c] + stm_pkg::IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        head_q[c] <= '0;
        fill_q[c] <= '0;
      end
    end else begin
      for (int c = 0; c < 2; c++) begin
        head_q[c] <= head_d[c];
        fill_q[c] <= fill_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      stamp_mem[wr_addr] <= wr_stamp_i;
      tag_mem[wr_addr]   <= wr_tag_i;
    end
    if (cmd_i.rd_en) begin
      stamp_left_q  <= stamp_mem[rd_addr_left];
      stamp_right_q <= stamp_mem[rd_addr_right];
      tag_left_q    <= tag_mem[rd_addr_left];
      tag_right_q   <= tag_mem[rd_addr_right];
    end
  end

  assign stat_o.ne_left    = (fill_q[0] != '0);
  assign stat_o.ne_right   = (fill_q[1] != '0);
  assign stat_o.full_left  = (fill_q[0] == stm_pkg::CNT_W'(stm_pkg::QUEUE_DEPTH));
  assign stat_o.full_right = (fill_q[1] == stm_pkg::CNT_W'(stm_pkg::QUEUE_DEPTH));

  assign stamp_left_o  = stamp_left_q;
  assign stamp_right_o = stamp_right_q;
  assign tag_left_o    = tag_left_q;
  assign tag_right_o   = tag_right_q;

endmodule

// ===== rtl/core/stm_alu.sv =====
// Shared 64-bit subtractor that forms the head difference and then its magnitude.
// Depends on stm_pkg for widths and the command and status structs.
module stm_alu (
  input  logic                         clk_i,
  input  stm_pkg::alu_cmd_t            cmd_i,
  input  logic [stm_pkg::STAMP_W-1:0]  stamp_left_i,
  input  logic [stm_pkg::STAMP_W-1:0]  stamp_right_i,
  input  logic [stm_pkg::WIN_W-1:0]    window_i,
  output stm_pkg::alu_stat_t           stat_o
);

  logic [stm_pkg::STAMP_W-1:0] acc_q, acc_d;
  logic                        neg_q, neg_d;
  logic                        nonzero_q, nonzero_d;
  logic [stm_pkg::STAMP_W-1:0] op_x, op_y, diff;

  // One adder serves both steps: left minus right, then zero minus a negative difference.
  always_comb begin
    op_x = cmd_i.sub_en ? stamp_left_i : '0;
    op_y = cmd_i.sub_en ? stamp_right_i : acc_q;
    diff = op_x + ~op_y + stm_pkg::STAMP_W'(1);
  end

  always_comb begin
    acc_d     = acc_q;
    neg_d     = neg_q;
    nonzero_d = nonzero_q;
    if (cmd_i.sub_en) begin
      acc_d     = diff;
      neg_d     = diff[stm_pkg::STAMP_W-1];
      nonzero_d = (diff != '0);
    end else if (cmd_i.abs_en && neg_q) begin
      acc_d = diff;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    neg_q     <= neg_d;
    nonzero_q <= nonzero_d;
  end

  assign stat_o.in_win  = (acc_q[stm_pkg::STAMP_W-1:stm_pkg::WIN_W] == '0) &&
                          (acc_q[stm_pkg::WIN_W-1:0] <= window_i);
  assign stat_o.neg     = neg_q;
  assign stat_o.nonzero = nonzero_q;

endmodule

// ===== rtl/core/stm_ctrl.sv =====
// Sequencer: stores or rejects a frame, steps the shared unit once per comparison.
// Depends on stm_pkg for the state enum, result codes and control structs.
module stm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 cam_i,
  input  stm_pkg::q_stat_t     q_stat_i,
  input  stm_pkg::alu_stat_t   alu_stat_i,
  input  logic                 out_free_i,
  output logic                 busy_o,
  output stm_pkg::q_cmd_t      q_cmd_o,
  output stm_pkg::alu_cmd_t    alu_cmd_o,
  output stm_pkg::emit_t       emit_o
);

  stm_pkg::state_e state_q, state_d;
  stm_pkg::kind_e  kind_q, kind_d;
  logic            cam_q, cam_d;
  logic [stm_pkg::CNT_W-1:0] cnt_q, cnt_d;

  logic            full_sel, other_ne, last;
  stm_pkg::kind_e  dec_kind;
  logic            dec_cam;

  assign full_sel = cam_i ? q_stat_i.full_right : q_stat_i.full_left;
  assign other_ne = cam_i ? q_stat_i.ne_left : q_stat_i.ne_right;

  // Pair when within the window, otherwise release the older head.
  always_comb begin
    if (alu_stat_i.in_win) begin
      dec_kind = stm_pkg::KIND_PAIR;
      dec_cam  = 1'b0;
    end else if (!alu_stat_i.neg && alu_stat_i.nonzero) begin
      dec_kind = stm_pkg::KIND_RELEASE;
      dec_cam  = 1'b1;
    end else begin
      dec_kind = stm_pkg::KIND_RELEASE;
      dec_cam  = 1'b0;
    end
  end

  // Queue levels already reflect the pops made in the decide step.
  assign last = (kind_q == stm_pkg::KIND_REJECT) ||
                !(q_stat_i.ne_left && q_stat_i.ne_right &&
                  ((cnt_q + stm_pkg::CNT_W'(1)) < stm_pkg::CNT_W'(stm_pkg::QUEUE_DEPTH)));

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cam_d   = cam_q;
    cnt_d   = cnt_q;
    case (state_q)
      stm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stm_pkg::ST_STORE;
        end
      end
      stm_pkg::ST_STORE: begin
        cnt_d = '0;
        if (full_sel) begin
          kind_d  = stm_pkg::KIND_REJECT;
          cam_d   = cam_i;
          state_d = stm_pkg::ST_EMIT;
        end else if (other_ne) begin
          state_d = stm_pkg::ST_READ;
        end else begin
          state_d = stm_pkg::ST_IDLE;
        end
      end
      stm_pkg::ST_READ:   state_d = stm_pkg::ST_SUB;
      stm_pkg::ST_SUB:    state_d = stm_pkg::ST_ABS;
      stm_pkg::ST_ABS:    state_d = stm_pkg::ST_DECIDE;
      stm_pkg::ST_DECIDE: begin
        kind_d  = dec_kind;
        cam_d   = dec_cam;
        state_d = stm_pkg::ST_EMIT;
      end
      stm_pkg::ST_EMIT: begin
        if (out_free_i) begin
          cnt_d   = cnt_q + stm_pkg::CNT_W'(1);
          state_d = last ? stm_pkg::ST_IDLE : stm_pkg::ST_READ;
        end
      end
      default: state_d = stm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o              = (state_q != stm_pkg::ST_IDLE);
    q_cmd_o.wr_en       = (state_q == stm_pkg::ST_STORE) && !full_sel;
    q_cmd_o.rd_en       = (state_q == stm_pkg::ST_READ);
    q_cmd_o.pop_left    = 1'b0;
    q_cmd_o.pop_right   = 1'b0;
    if (state_q == stm_pkg::ST_DECIDE) begin
      q_cmd_o.pop_left  = (dec_kind == stm_pkg::KIND_PAIR) || !dec_cam;
      q_cmd_o.pop_right = (dec_kind == stm_pkg::KIND_PAIR) || dec_cam;
    end
    alu_cmd_o.sub_en    = (state_q == stm_pkg::ST_SUB);
    alu_cmd_o.abs_en    = (state_q == stm_pkg::ST_ABS);
    emit_o.load         = (state_q == stm_pkg::ST_EMIT) && out_free_i;
    emit_o.kind         = kind_q;
    emit_o.cam          = cam_q;
    emit_o.last         = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stm_pkg::ST_IDLE;
      kind_q  <= stm_pkg::KIND_PAIR;
      cam_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      cam_q   <= cam_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/stereo_timestamp_matcher.sv =====
// Top level of the stereo timestamp matcher: ports, window register, output register.
// Depends on stm_pkg, stm_queue, stm_alu and stm_ctrl.
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/in_stall_o camera_i, tag_i, stamp_i
//   out      output     out_valid_o/out_stall_i kind_o, camera_out_o, tag_a_o, tag_b_o, last_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i (match window)
//
// A request that only fills a queue ends after the store step; a rejected one also
// emits its reject. Each head comparison steps through read, subtract, magnitude,
// decide and emit on the one shared 64-bit subtractor.
// Reset clears both queues and loads the window with 3000000; no clearing pass.
// in_stall_o is high from acceptance until the frame is stored or its last result is loaded;
// a stalled output holds its result while the next comparison proceeds up to the emit step.
module stereo_timestamp_matcher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        camera_i,
  input  logic [stm_pkg::TAG_W-1:0]   tag_i,
  input  logic [stm_pkg::STAMP_W-1:0] stamp_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic                        camera_out_o,
  output logic [stm_pkg::TAG_W-1:0]   tag_a_o,
  output logic [stm_pkg::TAG_W-1:0]   tag_b_o,
  output logic                        last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [stm_pkg::WIN_W-1:0]   cfg_data_i
);

  logic                         busy, in_accept, out_free;
  logic [stm_pkg::WIN_W-1:0]    window_q;
  logic                         cam_q;
  logic [stm_pkg::TAG_BITS-1:0] tag_q;
  logic [stm_pkg::STAMP_W-1:0]  stamp_q;

  stm_pkg::q_cmd_t    q_cmd;
  stm_pkg::q_stat_t   q_stat;
  stm_pkg::alu_cmd_t  alu_cmd;
  stm_pkg::alu_stat_t alu_stat;
  stm_pkg::emit_t     emit;

  logic [stm_pkg::STAMP_W-1:0]  head_stamp_left, head_stamp_right;
  logic [stm_pkg::TAG_BITS-1:0] head_tag_left, head_tag_right;

  logic                        out_valid_q, out_valid_d;
  stm_pkg::kind_e              out_kind_q;
  logic                        out_cam_q, out_last_q;
  logic [stm_pkg::TAG_W-1:0]   out_tag_a_q, out_tag_b_q, tag_a_d, tag_b_d;

  assign in_stall_o  = busy;
  assign in_accept   = in_valid_i && !busy;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= stm_pkg::WINDOW_RESET;
    end else if (cfg_valid_i) begin
      window_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cam_q   <= camera_i;
      tag_q   <= tag_i[stm_pkg::TAG_BITS-1:0];
      stamp_q <= stamp_i;
    end
  end

  stm_queue u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (q_cmd),
    .wr_cam_i      (cam_q),
    .wr_tag_i      (tag_q),
    .wr_stamp_i    (stamp_q),
    .stat_o        (q_stat),
    .stamp_left_o  (head_stamp_left),
    .stamp_right_o (head_stamp_right),
    .tag_left_o    (head_tag_left),
    .tag_right_o   (head_tag_right)
  );

  stm_alu u_alu (
    .clk_i         (clk_i),
    .cmd_i         (alu_cmd),
    .stamp_left_i  (head_stamp_left),
    .stamp_right_i (head_stamp_right),
    .window_i      (window_q),
    .stat_o        (alu_stat)
  );

  stm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cam_i      (cam_q),
    .q_stat_i   (q_stat),
    .alu_stat_i (alu_stat),
    .out_free_i (out_free),
    .busy_o     (busy),
    .q_cmd_o    (q_cmd),
    .alu_cmd_o  (alu_cmd),
    .emit_o     (emit)
  );

  always_comb begin
    tag_b_d = '0;
    case (emit.kind)
      stm_pkg::KIND_PAIR: begin
        tag_a_d = stm_pkg::TAG_W'(head_tag_left);
        tag_b_d = stm_pkg::TAG_W'(head_tag_right);
      end
      stm_pkg::KIND_RELEASE: begin
        tag_a_d = emit.cam ? stm_pkg::TAG_W'(head_tag_right)
                           : stm_pkg::TAG_W'(head_tag_left);
      end
      stm_pkg::KIND_REJECT: tag_a_d = stm_pkg::TAG_W'(tag_q);
      default:              tag_a_d = '0;
    endcase
  end

  assign out_valid_d = emit.load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_kind_q  <= emit.kind;
      out_cam_q   <= emit.cam;
      out_last_q  <= emit.last;
      out_tag_a_q <= tag_a_d;
      out_tag_b_q <= tag_b_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign camera_out_o = out_cam_q;
  assign tag_a_o      = out_tag_a_q;
  assign tag_b_o      = out_tag_b_q;
  assign last_o       = out_last_q;

endmodule

// ===== tb/stm_checker.sv =====
// Checker for the stereo timestamp matcher: watches the frame, result and window channels,
// keeps its own copy of both camera queues and compares every result with its prediction.
// Depends on stm_pkg.
`timescale 1ns / 1ps

module stm_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        camera_i,
  input  logic [stm_pkg::TAG_W-1:0]   tag_i,
  input  logic [stm_pkg::STAMP_W-1:0] stamp_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [1:0]                  kind_i,
  input  logic                        camera_out_i,
  input  logic [stm_pkg::TAG_W-1:0]   tag_a_i,
  input  logic [stm_pkg::TAG_W-1:0]   tag_b_i,
  input  logic                        last_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [stm_pkg::WIN_W-1:0]   cfg_data_i,
  output int                          err_count_o,
  output int                          outstanding_o
);

  typedef struct packed {
    stm_pkg::kind_e            kind;
    logic                      cam;
    logic [stm_pkg::TAG_W-1:0] tag_a;
    logic [stm_pkg::TAG_W-1:0] tag_b;
    logic                      last;
  } frame_result_t;

  logic [stm_pkg::STAMP_W-1:0] stamp_mem [2][stm_pkg::QUEUE_DEPTH];
  logic [stm_pkg::TAG_W-1:0]   tag_mem   [2][stm_pkg::QUEUE_DEPTH];
  int unsigned                 head [2];
  int unsigned                 fill [2];
  logic [stm_pkg::WIN_W-1:0]   window;
  frame_result_t               pending_results [$];
  int                          mismatches = 0;

  assign err_count_o = mismatches;

  function automatic void add_result(frame_result_t res);
    pending_results.insert(pending_results.size(), res);
  endfunction

  function automatic void pop_head(int cam);
    head[cam] = (head[cam] + 1) % stm_pkg::QUEUE_DEPTH;
    fill[cam] = fill[cam] - 1;
  endfunction

  // Stores or rejects a frame, then pairs or releases heads until a queue runs dry.
  function automatic void match_frame(logic cam, logic [stm_pkg::TAG_W-1:0] tag,
                                      logic [stm_pkg::STAMP_W-1:0] stamp);
    frame_result_t               res;
    frame_result_t               prev;
    logic                        have_prev;
    logic [stm_pkg::STAMP_W-1:0] diff;
    logic [stm_pkg::STAMP_W-1:0] mag;
    logic [stm_pkg::TAG_W-1:0]   kept_tag;
    int                          n;
    int unsigned                 slot;
    int unsigned                 l;
    int unsigned                 r;
    kept_tag = tag & stm_pkg::TAG_W'((1 << stm_pkg::TAG_BITS) - 1);
    if (fill[cam] >= stm_pkg::QUEUE_DEPTH) begin
      res = '{stm_pkg::KIND_REJECT, cam, kept_tag, '0, 1'b1};
      add_result(res);
      return;
    end
    slot = (head[cam] + fill[cam]) % stm_pkg::QUEUE_DEPTH;
    stamp_mem[cam][slot] = stamp;
    tag_mem[cam][slot] = kept_tag;
    fill[cam] = fill[cam] + 1;
    n = 0;
    have_prev = 1'b0;
    while (fill[0] != 0 && fill[1] != 0 && n < stm_pkg::QUEUE_DEPTH) begin
      l = head[0];
      r = head[1];
      diff = stamp_mem[0][l] - stamp_mem[1][r];
      mag = diff[stm_pkg::STAMP_W-1] ? -diff : diff;
      if (mag <= 64'(window)) begin
        res = '{stm_pkg::KIND_PAIR, 1'b0, tag_mem[0][l], tag_mem[1][r], 1'b0};
        pop_head(0);
        pop_head(1);
      end else if (!diff[stm_pkg::STAMP_W-1] && diff != '0) begin
        // Left is later, so the right head is the older frame.
        res = '{stm_pkg::KIND_RELEASE, 1'b1, tag_mem[1][r], '0, 1'b0};
        pop_head(1);
      end else begin
        res = '{stm_pkg::KIND_RELEASE, 1'b0, tag_mem[0][l], '0, 1'b0};
        pop_head(0);
      end
      if (have_prev) add_result(prev);
      prev = res;
      have_prev = 1'b1;
      n++;
    end
    if (have_prev) begin
      prev.last = 1'b1;
      add_result(prev);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      head[0] = 0;
      head[1] = 0;
      fill[0] = 0;
      fill[1] = 0;
      window = stm_pkg::WINDOW_RESET;
      pending_results.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t: unexpected result: expected none, got kind %0d cam %0d",
                     $time, kind_i, camera_out_i,
                     " tag_a %h tag_b %h last %0d", tag_a_i, tag_b_i, last_i);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (kind_i !== want.kind || camera_out_i !== want.cam ||
              tag_a_i !== want.tag_a || tag_b_i !== want.tag_b ||
              last_i !== want.last) begin
            mismatches++;
            if (mismatches <= 40)
              $display("%0t: result mismatch: expected kind %0d cam %0d", $time,
                       want.kind, want.cam,
                       " tag_a %h tag_b %h last %0d,", want.tag_a, want.tag_b, want.last,
                       " got kind %0d cam %0d", kind_i, camera_out_i,
                       " tag_a %h tag_b %h last %0d", tag_a_i, tag_b_i, last_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) match_frame(camera_i, tag_i, stamp_i);
      if (cfg_valid_i && cfg_ready_i) window = cfg_data_i;
      outstanding_o <= pending_results.size();
    end
  end

endmodule

// ===== tb/stereo_timestamp_matcher_tb.sv =====
// Testbench top of the stereo timestamp matcher: clock, reset, frame and window stimulus,
// receiver stalls and the verdict. Depends on stm_pkg, stm_checker and the matcher RTL.
`timescale 1ns / 1ps

module stereo_timestamp_matcher_tb;

  localparam int LIMIT     = 300000;
  localparam int SETTLE    = 30;
  localparam int LONG_HOLD = 400;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        camera_i;
  logic [stm_pkg::TAG_W-1:0]   tag_i;
  logic [stm_pkg::STAMP_W-1:0] stamp_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [1:0]                  kind_o;
  logic                        camera_out_o;
  logic [stm_pkg::TAG_W-1:0]   tag_a_o;
  logic [stm_pkg::TAG_W-1:0]   tag_b_o;
  logic                        last_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [stm_pkg::WIN_W-1:0]   cfg_data_i;

  int                        err_count;
  int                        outstanding;
  int                        cycles = 0;
  int                        tx_idle_pct = 31;
  int                        rx_idle_pct = 77;
  int                        hold_requests = 0;
  int                        holds_served = 0;
  int                        hold_left = 0;
  logic [stm_pkg::WIN_W-1:0] window_now = stm_pkg::WINDOW_RESET;

  stereo_timestamp_matcher u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .camera_i     (camera_i),
    .tag_i        (tag_i),
    .stamp_i      (stamp_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .camera_out_o (camera_out_o),
    .tag_a_o      (tag_a_o),
    .tag_b_o      (tag_b_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  stm_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .camera_i      (camera_i),
    .tag_i         (tag_i),
    .stamp_i       (stamp_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_i        (kind_o),
    .camera_out_i  (camera_out_o),
    .tag_a_i       (tag_a_o),
    .tag_b_i       (tag_b_o),
    .last_i        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .err_count_o   (err_count),
    .outstanding_o (outstanding)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("[stereo_timestamp_matcher] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
  always @(posedge clk_i) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_frame(input logic cam, input logic [stm_pkg::TAG_W-1:0] tag,
                            input logic [stm_pkg::STAMP_W-1:0] stamp);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    camera_i <= cam;
    tag_i <= tag;
    stamp_i <= stamp;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops offering requests until every expected result is out and the block is quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [stm_pkg::WIN_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    window_now = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly frame pairs around a common frame time with jitter near the window, some with
  // a dropped side; the rest are single-camera bursts and frames with random timestamps.
  task automatic random_frames(input int count);
    int                          sent;
    int                          mode;
    logic                        first;
    logic [stm_pkg::STAMP_W-1:0] base;
    logic [stm_pkg::STAMP_W-1:0] jit;
    sent = 0;
    base = {$urandom, $urandom};
    jit = 64'(window_now) + 64'(window_now >> 1) + 64'd1;
    while (sent < count) begin
      mode = $urandom_range(99);
      base = base + 64'd33_333_333;
      if (mode < 10) begin
        send_frame(1'($urandom_range(1)), 8'($urandom_range(255)), {$urandom, $urandom});
        sent++;
      end else if (mode < 18) begin
        first = 1'($urandom_range(1));
        for (int k = 0; k < 5; k++) begin
          send_frame(first, 8'($urandom_range(255)), base + 64'(k * 1000));
          sent++;
        end
      end else begin
        first = 1'($urandom_range(1));
        for (int k = 0; k < 2; k++) begin
          if ($urandom_range(9) != 0) begin
            send_frame(first ^ k[0], 8'($urandom_range(255)),
                       base + ({$urandom, $urandom} % jit));
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    camera_i = 1'b0;
    tag_i = '0;
    stamp_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset window: fill the left queue, overflow it, then pair and
    // release against the right camera, including the most negative difference.
    send_frame(1'b0, 8'h00, 64'd0);
    send_frame(1'b0, 8'hFF, 64'd1000);
    send_frame(1'b0, 8'h55, 64'd2000);
    send_frame(1'b0, 8'hAA, 64'd3000);
    send_frame(1'b0, 8'h11, 64'd4000);
    send_frame(1'b1, 8'h80, 64'd3_000_000);
    send_frame(1'b1, 8'h01, 64'd3_001_001);
    send_frame(1'b1, 8'h7F, 64'h8000_0000_0000_0BB8);
    send_frame(1'b0, 8'hC3, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(1'b1, 8'h3C, 64'd0);
    // Four old left frames, then one late right frame releases all of them.
    send_frame(1'b0, 8'h01, 64'd10);
    send_frame(1'b0, 8'h02, 64'd20);
    send_frame(1'b0, 8'h04, 64'd30);
    send_frame(1'b0, 8'h08, 64'd40);
    send_frame(1'b1, 8'h10, 64'd40_000_000);
    send_frame(1'b1, 8'h20, 64'd40_000_001);
    send_frame(1'b1, 8'h40, 64'd40_000_002);
    send_frame(1'b1, 8'h80, 64'd40_000_003);
    send_frame(1'b1, 8'hFE, 64'd40_000_004);
    send_frame(1'b0, 8'hEF, 64'd40_000_002);
    // A zero window still pairs equal timestamps.
    set_window('0);
    send_frame(1'b0, 8'h00, 64'd40_000_001);
    send_frame(1'b0, 8'h33, 64'd40_000_003);

    set_window($urandom_range(10_000_000, 100_000));
    random_frames(15);
    hold_requests <= hold_requests + 1;
    random_frames(15);

    set_window('1);
    tx_idle_pct = 77;
    rx_idle_pct <= 31;
    random_frames(35);

    set_window($urandom);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    random_frames(35);

    drain();
    if (err_count == 0 && outstanding == 0) begin
      $display("[stereo_timestamp_matcher] OK");
    end else begin
      $display("[stereo_timestamp_matcher] ERROR");
    end
    $finish;
  end

endmodule
